// ----- rtl/core/fha_pkg.sv -----
// Shared types and codes for the first-fit heap allocator.
// Holds the controller command, datapath status and result codes; no dependencies.
`default_nettype none

package fha_pkg;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic REG_HEAP_BYTES = 1'b0;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_FIT    = 3'd1,
      ST_ZERO_SIZE = 3'd2,
      ST_NULL_FREE = 3'd3,
      ST_BAD_FREE  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_CLEAR,
      DP_LOAD,
      DP_READ_CUR,
      DP_STEP,
      DP_TAKE_CUR,
      DP_READ_G,
      DP_TAKE_G,
      DP_WR_SPLIT,
      DP_WR_CUR,
      DP_WR_PREV_ALLOC,
      DP_WR_G,
      DP_WR_PREV_FREE,
      DP_FINISH
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic zero_req;
      logic free_null;
      logic free_bad;
      logic have;
      logic steps_ok;
      logic fits;
      logic cur_lt_g;
      logic rd_used;
      logic clr_last;
      logic rsp_full;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/first_fit_heap_allocator.sv -----
// First-fit heap allocator. After acceptance an allocate walks the free list until a
// block fits or the list ends, a free walks the free blocks ahead of it; zero-size and
// bad-address requests skip the walk. The next request is taken after the result beat
// is registered, while that beat may still wait. After reset and each heap_bytes write,
// requests wait while all MAX_HEAP_BYTES/ALIGN_BYTES (8192 by default) entries clear.
// Depends on fha_pkg, fha_ctrl, fha_dp and fha_ram.
`default_nettype none

module first_fit_heap_allocator #(
   parameter int ALIGN_BYTES     = 8,
   parameter int HEADER_BYTES    = 8,
   parameter int MIN_BLOCK_BYTES = 16,
   parameter int MAX_HEAP_BYTES  = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // req_bytes[16:0], addr[32:17], zero pad
   input  wire logic [0:0]  req_tuser,   // func[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // payload_addr[15:0], free_total[32:16], free_low_mark[49:33],
   // live_blocks[62:50], live_blocks_peak[75:63], heap_total[92:76], zero pad
   output logic [95:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,   // status[2:0]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [16:0]       heap_bytes_ff;
   logic              cfg_wr;
   fha_pkg::cmd_type  cmd;
   fha_pkg::stat_type st;

   logic [15:0] pay;
   logic [16:0] ft, fl, ht;
   logic [12:0] lb, lp;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == fha_pkg::REG_HEAP_BYTES);
   assign csr_prdata = (csr_paddr[2] == fha_pkg::REG_HEAP_BYTES) ?
                       {15'd0, heap_bytes_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= 17'd65536;
      end else if (cfg_wr) begin
         heap_bytes_ff <= csr_pwdata[16:0];
      end
   end

   fha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_init   (cfg_wr),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   fha_dp #(
      .ALIGN_BYTES     (ALIGN_BYTES),
      .HEADER_BYTES    (HEADER_BYTES),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
      .MAX_HEAP_BYTES  (MAX_HEAP_BYTES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cfg_init             (cfg_wr),
      .cmd                  (cmd),
      .st                   (st),
      .req_func             (req_tuser[0]),
      .req_bytes            (req_tdata[16:0]),
      .req_addr             (req_tdata[32:17]),
      .heap_bytes           (heap_bytes_ff),
      .rsp_tready           (rsp_tready),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_status           (rsp_tuser),
      .rsp_payload_addr     (pay),
      .rsp_free_total       (ft),
      .rsp_free_low_mark    (fl),
      .rsp_live_blocks      (lb),
      .rsp_live_blocks_peak (lp),
      .rsp_heap_total       (ht)
   );

   assign rsp_tdata = {3'd0, ht, lp, lb, fl, ft, pay};

endmodule

`default_nettype wire

// ----- rtl/core/fha_ram.sv -----
// Generic single-port RAM with registered read data.
// Used for the header store; no dependencies.
`default_nettype none

module fha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/fha_ctrl.sv -----
// Sequencer for the heap allocator: clearing pass, free-list walks and updates.
// Depends on fha_pkg for command and status types.
`default_nettype none

module fha_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cfg_init,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire fha_pkg::stat_type st,
   output fha_pkg::cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_BEGIN,
      A_RD, A_CHK, A_W1, A_W2, A_W3,
      F_CHKG, F_RD, F_STEP, F_TAKEC, F_WG, F_WP,
      S_FIN
   } state_type;

   state_type            state_ff, state_in;
   fha_pkg::status_type  code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset || cfg_init) begin
         state_ff <= S_CLEAR;
         code_ff  <= fha_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd.op   = fha_pkg::DP_NONE;
      cmd.code = code_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = fha_pkg::DP_CLEAR;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = fha_pkg::DP_LOAD;
               state_in = S_BEGIN;
            end
         end
         S_BEGIN: begin
            if (st.is_free) begin
               if (st.free_null) begin
                  code_in = fha_pkg::ST_NULL_FREE; state_in = S_FIN;
               end else if (st.free_bad) begin
                  code_in = fha_pkg::ST_BAD_FREE; state_in = S_FIN;
               end else begin
                  cmd.op = fha_pkg::DP_READ_G; state_in = F_CHKG;
               end
            end else if (st.zero_req) begin
               code_in = fha_pkg::ST_ZERO_SIZE; state_in = S_FIN;
            end else begin
               state_in = A_RD;
            end
         end
         A_RD: begin
            if (st.have && st.steps_ok) begin
               cmd.op = fha_pkg::DP_READ_CUR; state_in = A_CHK;
            end else begin
               code_in = fha_pkg::ST_NO_FIT; state_in = S_FIN;
            end
         end
         A_CHK: begin
            if (st.fits) begin
               cmd.op = fha_pkg::DP_TAKE_CUR; state_in = A_W1;
            end else begin
               cmd.op = fha_pkg::DP_STEP; state_in = A_RD;
            end
         end
         A_W1: begin
            cmd.op = fha_pkg::DP_WR_SPLIT; state_in = A_W2;
         end
         A_W2: begin
            cmd.op = fha_pkg::DP_WR_CUR; state_in = A_W3;
         end
         A_W3: begin
            cmd.op = fha_pkg::DP_WR_PREV_ALLOC;
            code_in = fha_pkg::ST_OK; state_in = S_FIN;
         end
         F_CHKG: begin
            if (!st.rd_used) begin
               code_in = fha_pkg::ST_BAD_FREE; state_in = S_FIN;
            end else begin
               cmd.op = fha_pkg::DP_TAKE_G; state_in = F_RD;
            end
         end
         F_RD: begin
            if (st.have && st.cur_lt_g && st.steps_ok) begin
               cmd.op = fha_pkg::DP_READ_CUR; state_in = F_STEP;
            end else if (st.have) begin
               cmd.op = fha_pkg::DP_READ_CUR; state_in = F_TAKEC;
            end else begin
               state_in = F_WG;
            end
         end
         F_STEP: begin
            cmd.op = fha_pkg::DP_STEP; state_in = F_RD;
         end
         F_TAKEC: begin
            cmd.op = fha_pkg::DP_TAKE_CUR; state_in = F_WG;
         end
         F_WG: begin
            cmd.op = fha_pkg::DP_WR_G; state_in = F_WP;
         end
         F_WP: begin
            cmd.op = fha_pkg::DP_WR_PREV_FREE;
            code_in = fha_pkg::ST_OK; state_in = S_FIN;
         end
         S_FIN: begin
            if (!st.rsp_full) begin
               cmd.op = fha_pkg::DP_FINISH; state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/fha_dp.sv -----
// Datapath of the heap allocator: header store, list walk registers,
// statistics and the result register. Depends on fha_pkg and fha_ram.
`default_nettype none

module fha_dp #(
   parameter int ALIGN_BYTES     = 8,
   parameter int HEADER_BYTES    = 8,
   parameter int MIN_BLOCK_BYTES = 16,
   parameter int MAX_HEAP_BYTES  = 65536
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cfg_init,
   input  wire fha_pkg::cmd_type cmd,
   output fha_pkg::stat_type     st,
   input  wire logic             req_func,
   input  wire logic [16:0]      req_bytes,
   input  wire logic [15:0]      req_addr,
   input  wire logic [16:0]      heap_bytes,
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   output logic [2:0]            rsp_status,
   output logic [15:0]           rsp_payload_addr,
   output logic [16:0]           rsp_free_total,
   output logic [16:0]           rsp_free_low_mark,
   output logic [12:0]           rsp_live_blocks,
   output logic [12:0]           rsp_live_blocks_peak,
   output logic [16:0]           rsp_heap_total
);

   localparam int GRAN   = MAX_HEAP_BYTES / ALIGN_BYTES;
   localparam int GW     = $clog2(GRAN);
   localparam int SW     = GW + 1;
   localparam int ALW    = $clog2(ALIGN_BYTES);
   localparam int XW     = ((SW > 18) ? SW : 18) + 2;
   localparam int MINB_G = (MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;

   // Sizes are kept in granules; all block sizes are whole granules.
   typedef struct packed {
      logic [SW-1:0] size;
      logic [GW-1:0] nxt;
      logic          link;
      logic          used;
   } entry_type;

   localparam int EW = $bits(entry_type);

   logic            func_ff;
   logic [16:0]     rbytes_ff;
   logic [15:0]     raddr_ff;
   logic [GW-1:0]   head_ff, cur_ff, prev_ff, clr_ff;
   logic            nonempty_ff, have_ff, have_prev_ff;
   logic [SW-1:0]   steps_ff, op_sz_ff;
   entry_type       cur_e_ff, prev_e_ff, g_e_ff;
   logic [SW-1:0]   fc_ff, fmin_ff;
   logic [SW-1:0]   live_ff, peak_ff;

   logic            rsp_valid_ff;
   logic [2:0]      rsp_status_ff;
   logic [15:0]     rsp_pay_ff;
   logic [16:0]     rsp_ft_ff, rsp_fl_ff, rsp_ht_ff;
   logic [12:0]     rsp_lb_ff, rsp_lp_ff;

   logic [EW-1:0]   ram_rdata, ram_wdata;
   logic [GW-1:0]   ram_addr;
   logic            ram_we;
   entry_type       rd, wr;

   logic [SW-1:0]   ht_g;
   logic [XW-1:0]   tg;
   logic            do_split, merge_nx, merge_pv;
   logic [GW-1:0]   nxt_g, g_idx;
   logic [15:0]     blk;
   entry_type       g_new;
   logic [SW-1:0]   fc_new, fmin_new, live_new, peak_new;

   assign rd = entry_type'(ram_rdata);

   fha_ram #(.WIDTH(EW), .DEPTH(GRAN)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Aligned heap size in granules, clamped to the minimum block and the maximum.
   always_comb begin
      logic [XW-1:0] hs;
      hs = (XW'(heap_bytes) + XW'(ALIGN_BYTES - 1)) >> ALW;
      if (hs < XW'(MINB_G)) hs = XW'(MINB_G);
      if (hs > XW'(GRAN)) hs = XW'(GRAN);
      ht_g = SW'(hs);
   end

   always_comb begin
      logic [XW-1:0] tsum;
      tsum = XW'(rbytes_ff) + XW'(HEADER_BYTES + ALIGN_BYTES - 1);
      tg   = tsum >> ALW;
      if (tg < XW'(MINB_G)) tg = XW'(MINB_G);
   end

   assign do_split = (XW'(cur_e_ff.size) >= tg + XW'(MINB_G)) &&
                     (XW'(cur_ff) + tg < XW'(GRAN));
   assign nxt_g    = GW'(XW'(cur_ff) + tg);
   assign blk      = raddr_ff - 16'(HEADER_BYTES);
   assign g_idx    = GW'(XW'(blk) >> ALW);

   assign merge_nx = have_ff && (XW'(g_idx) + XW'(g_e_ff.size) == XW'(cur_ff));
   assign merge_pv = have_prev_ff && (XW'(prev_ff) + XW'(prev_e_ff.size) == XW'(g_idx));

   always_comb begin
      g_new.size = merge_nx ? g_e_ff.size + cur_e_ff.size : g_e_ff.size;
      g_new.nxt  = merge_nx ? cur_e_ff.nxt : cur_ff;
      g_new.link = merge_nx ? cur_e_ff.link : have_ff;
      g_new.used = 1'b0;
   end

   // Store address and write data for each command.
   always_comb begin
      ram_addr = cur_ff;
      ram_we   = 1'b0;
      wr       = '0;
      case (cmd.op)
         fha_pkg::DP_CLEAR: begin
            ram_addr = clr_ff;
            ram_we   = 1'b1;
            if (clr_ff == '0) wr.size = ht_g;
         end
         fha_pkg::DP_READ_G: ram_addr = g_idx;
         fha_pkg::DP_WR_SPLIT: begin
            ram_addr = nxt_g;
            ram_we   = do_split;
            wr.size  = cur_e_ff.size - SW'(tg);
            wr.nxt   = cur_e_ff.nxt;
            wr.link  = cur_e_ff.link;
         end
         fha_pkg::DP_WR_CUR: begin
            ram_we   = 1'b1;
            wr       = cur_e_ff;
            wr.size  = do_split ? SW'(tg) : cur_e_ff.size;
            wr.used  = 1'b1;
         end
         fha_pkg::DP_WR_PREV_ALLOC: begin
            ram_addr = prev_ff;
            ram_we   = have_prev_ff;
            wr       = prev_e_ff;
            wr.nxt   = do_split ? nxt_g : cur_e_ff.nxt;
            wr.link  = do_split ? 1'b1 : cur_e_ff.link;
         end
         fha_pkg::DP_WR_G: begin
            ram_addr = g_idx;
            ram_we   = 1'b1;
            wr       = g_new;
         end
         fha_pkg::DP_WR_PREV_FREE: begin
            ram_addr = prev_ff;
            ram_we   = have_prev_ff;
            wr       = prev_e_ff;
            if (merge_pv) begin
               wr.size = prev_e_ff.size + g_e_ff.size;
               wr.nxt  = g_e_ff.nxt;
               wr.link = g_e_ff.link;
            end else begin
               wr.nxt  = g_idx;
               wr.link = 1'b1;
            end
         end
         default: ;
      endcase
      ram_wdata = EW'(wr);
   end

   // Statistics after a successful operation.
   always_comb begin
      logic [SW:0] fsum;
      fc_new   = fc_ff;
      fmin_new = fmin_ff;
      live_new = live_ff;
      peak_new = peak_ff;
      fsum     = {1'b0, fc_ff} + {1'b0, op_sz_ff};
      if (func_ff == fha_pkg::FUNC_ALLOC) begin
         fc_new   = (fc_ff >= op_sz_ff) ? fc_ff - op_sz_ff : '0;
         fmin_new = (fc_new < fmin_ff) ? fc_new : fmin_ff;
         live_new = live_ff + SW'(1);
         peak_new = (live_new > peak_ff) ? live_new : peak_ff;
      end else begin
         fc_new   = (fsum > {1'b0, ht_g}) ? ht_g : SW'(fsum);
         live_new = (live_ff != '0) ? live_ff - SW'(1) : live_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_init) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (cmd.op != fha_pkg::DP_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            fha_pkg::DP_CLEAR: begin
               clr_ff <= clr_ff + GW'(1);
               if (clr_ff == '0) begin
                  head_ff     <= '0;
                  nonempty_ff <= 1'b1;
                  fc_ff       <= ht_g;
                  fmin_ff     <= ht_g;
                  live_ff     <= '0;
                  peak_ff     <= '0;
               end
            end
            fha_pkg::DP_LOAD: begin
               func_ff      <= req_func;
               rbytes_ff    <= req_bytes;
               raddr_ff     <= req_addr;
               cur_ff       <= head_ff;
               have_ff      <= nonempty_ff;
               have_prev_ff <= 1'b0;
               steps_ff     <= '0;
            end
            fha_pkg::DP_STEP: begin
               prev_ff      <= cur_ff;
               prev_e_ff    <= rd;
               have_prev_ff <= 1'b1;
               have_ff      <= rd.link;
               cur_ff       <= rd.nxt;
               steps_ff     <= steps_ff + SW'(1);
            end
            fha_pkg::DP_TAKE_CUR: cur_e_ff <= rd;
            fha_pkg::DP_TAKE_G: begin
               g_e_ff   <= rd;
               op_sz_ff <= rd.size;
            end
            fha_pkg::DP_WR_CUR: op_sz_ff <= wr.size;
            fha_pkg::DP_WR_PREV_ALLOC: begin
               if (!have_prev_ff) begin
                  head_ff     <= do_split ? nxt_g : cur_e_ff.nxt;
                  nonempty_ff <= do_split ? 1'b1 : cur_e_ff.link;
               end
            end
            fha_pkg::DP_WR_G: g_e_ff <= g_new;
            fha_pkg::DP_WR_PREV_FREE: begin
               if (!have_prev_ff) begin
                  head_ff     <= g_idx;
                  nonempty_ff <= 1'b1;
               end
            end
            fha_pkg::DP_FINISH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= cmd.code;
               if ((cmd.code == fha_pkg::ST_OK) && (func_ff == fha_pkg::FUNC_ALLOC)) begin
                  rsp_pay_ff <= 16'(XW'({cur_ff, {ALW{1'b0}}}) + XW'(HEADER_BYTES));
               end else begin
                  rsp_pay_ff <= '0;
               end
               if (cmd.code == fha_pkg::ST_OK) begin
                  fc_ff   <= fc_new;
                  fmin_ff <= fmin_new;
                  live_ff <= live_new;
                  peak_ff <= peak_new;
                  rsp_ft_ff <= 17'({fc_new, {ALW{1'b0}}});
                  rsp_fl_ff <= 17'({fmin_new, {ALW{1'b0}}});
                  rsp_lb_ff <= 13'(live_new);
                  rsp_lp_ff <= 13'(peak_new);
               end else begin
                  rsp_ft_ff <= 17'({fc_ff, {ALW{1'b0}}});
                  rsp_fl_ff <= 17'({fmin_ff, {ALW{1'b0}}});
                  rsp_lb_ff <= 13'(live_ff);
                  rsp_lp_ff <= 13'(peak_ff);
               end
               rsp_ht_ff <= 17'({ht_g, {ALW{1'b0}}});
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      st.is_free   = (func_ff == fha_pkg::FUNC_FREE);
      st.zero_req  = (rbytes_ff == '0);
      st.free_null = (raddr_ff == '0);
      st.free_bad  = (raddr_ff < 16'(HEADER_BYTES)) || (blk[ALW-1:0] != '0) ||
                     (XW'(blk) >= XW'({ht_g, {ALW{1'b0}}}));
      st.have      = have_ff;
      st.steps_ok  = (steps_ff < SW'(GRAN));
      st.fits      = (XW'(rd.size) >= tg);
      st.cur_lt_g  = (cur_ff < g_idx);
      st.rd_used   = rd.used;
      st.clr_last  = (clr_ff == GW'(GRAN - 1));
      st.rsp_full  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid           = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_payload_addr     = rsp_pay_ff;
   assign rsp_free_total       = rsp_ft_ff;
   assign rsp_free_low_mark    = rsp_fl_ff;
   assign rsp_live_blocks      = rsp_lb_ff;
   assign rsp_live_blocks_peak = rsp_lp_ff;
   assign rsp_heap_total       = rsp_ht_ff;

endmodule

`default_nettype wire

// ----- verif/first_fit_heap_allocator_checker.sv -----
// Checker for the first-fit heap allocator: watches the request, result and register
// ports, predicts every result beat and compares it. Depends on fha_pkg.
`default_nettype none

module first_fit_heap_allocator_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,   // req_bytes[16:0], addr[32:17], zero pad
   input  wire logic [0:0]  req_tuser,   // func[0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // payload_addr[15:0], free_total[32:16], free_low_mark[49:33],
   // live_blocks[62:50], live_blocks_peak[75:63], heap_total[92:76], zero pad
   input  wire logic [95:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,   // status[2:0]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending
);

   localparam int ALIGN    = 8;
   localparam int HDR      = 8;
   localparam int MIN_BLK  = 16;
   localparam int MAX_HEAP = 65536;
   localparam int GRANULES = MAX_HEAP / ALIGN;

   typedef struct packed {
      fha_pkg::status_type status;
      logic [15:0] payload;
      logic [16:0] free_total;
      logic [16:0] free_low;
      logic [12:0] live;
      logic [12:0] peak;
      logic [16:0] heap_total;
   } heap_result_type;

   int unsigned blk_size [GRANULES];
   int unsigned blk_next [GRANULES];
   bit          blk_link [GRANULES];
   bit          blk_used [GRANULES];
   int unsigned head_g, free_bytes, free_low, live_cnt, peak_cnt, heap_span;
   bit          list_nonempty;

   heap_result_type expected_q[$];

   function automatic int unsigned round_to_align(int unsigned x);
      return (x + ALIGN - 1) / ALIGN * ALIGN;
   endfunction

   task automatic heap_init(logic [16:0] req);
      int unsigned v;
      v = round_to_align(req);
      if (v < round_to_align(MIN_BLK)) v = round_to_align(MIN_BLK);
      if (v > MAX_HEAP / ALIGN * ALIGN) v = MAX_HEAP / ALIGN * ALIGN;
      heap_span = v;
      for (int i = 0; i < GRANULES; i++) begin
         blk_size[i] = 0;
         blk_next[i] = 0;
         blk_link[i] = 0;
         blk_used[i] = 0;
      end
      blk_size[0] = v;
      head_g = 0;
      list_nonempty = 1;
      free_bytes = v;
      free_low = v;
      live_cnt = 0;
      peak_cnt = 0;
   endtask

   task automatic alloc_block(int unsigned req, output fha_pkg::status_type st,
                              output int unsigned pay);
      int unsigned need, cur, prev, steps, sz, nxt;
      bit have, have_prev, found;
      pay = 0;
      cur = head_g;
      prev = 0;
      steps = 0;
      have = list_nonempty;
      have_prev = 0;
      found = 0;
      if (req == 0) begin
         st = fha_pkg::ST_ZERO_SIZE;
         return;
      end
      need = round_to_align(req + HDR);
      if (need < round_to_align(MIN_BLK)) need = round_to_align(MIN_BLK);
      while (have && cur < GRANULES && steps < GRANULES) begin
         if (blk_size[cur] >= need) begin
            found = 1;
            break;
         end
         prev = cur;
         have_prev = 1;
         have = blk_link[cur];
         cur = blk_next[cur];
         steps++;
      end
      if (!found) begin
         st = fha_pkg::ST_NO_FIT;
         return;
      end
      sz = blk_size[cur];
      if (sz >= need + round_to_align(MIN_BLK) && cur + need / ALIGN < GRANULES) begin
         nxt = cur + need / ALIGN;
         blk_size[nxt] = sz - need;
         blk_next[nxt] = blk_next[cur];
         blk_link[nxt] = blk_link[cur];
         blk_used[nxt] = 0;
         blk_size[cur] = need;
         if (have_prev) begin
            blk_next[prev] = nxt;
            blk_link[prev] = 1;
         end else begin
            head_g = nxt;
            list_nonempty = 1;
         end
      end else if (have_prev) begin
         blk_next[prev] = blk_next[cur];
         blk_link[prev] = blk_link[cur];
      end else begin
         head_g = blk_next[cur];
         list_nonempty = blk_link[cur];
      end
      blk_used[cur] = 1;
      sz = blk_size[cur];
      free_bytes = (free_bytes >= sz) ? free_bytes - sz : 0;
      if (free_bytes < free_low) free_low = free_bytes;
      live_cnt++;
      if (live_cnt > peak_cnt) peak_cnt = live_cnt;
      pay = cur * ALIGN + HDR;
      st = fha_pkg::ST_OK;
   endtask

   // Puts granule g back in address order and merges it with each neighbour that it touches.
   task automatic insert_free(int unsigned g);
      int unsigned cur, prev, steps;
      bit have, have_prev;
      cur = head_g;
      prev = 0;
      steps = 0;
      have = list_nonempty;
      have_prev = 0;
      while (have && cur < g && steps < GRANULES) begin
         prev = cur;
         have_prev = 1;
         have = blk_link[cur];
         cur = blk_next[cur];
         steps++;
      end
      if (have && cur < GRANULES && g * ALIGN + blk_size[g] == cur * ALIGN) begin
         blk_size[g] += blk_size[cur];
         blk_next[g] = blk_next[cur];
         blk_link[g] = blk_link[cur];
      end else begin
         blk_next[g] = cur;
         blk_link[g] = have;
      end
      if (have_prev && prev * ALIGN + blk_size[prev] == g * ALIGN) begin
         blk_size[prev] += blk_size[g];
         blk_next[prev] = blk_next[g];
         blk_link[prev] = blk_link[g];
      end else if (have_prev) begin
         blk_next[prev] = g;
         blk_link[prev] = 1;
      end else begin
         head_g = g;
         list_nonempty = 1;
      end
   endtask

   task automatic free_block(int unsigned addr, output fha_pkg::status_type st);
      int unsigned start, g, sz;
      if (addr == 0) begin
         st = fha_pkg::ST_NULL_FREE;
         return;
      end
      st = fha_pkg::ST_BAD_FREE;
      if (addr < HDR) return;
      start = addr - HDR;
      if (start % ALIGN != 0 || start >= heap_span) return;
      g = start / ALIGN;
      if (g >= GRANULES || !blk_used[g]) return;
      blk_used[g] = 0;
      sz = blk_size[g];
      insert_free(g);
      free_bytes += sz;
      if (free_bytes > heap_span) free_bytes = heap_span;
      if (live_cnt > 0) live_cnt--;
      st = fha_pkg::ST_OK;
   endtask

   assign pending = expected_q.size();

   always @(posedge clock) begin
      fha_pkg::status_type st;
      int unsigned         pay;
      heap_result_type     exp_r, got_r;
      if (reset) begin
         heap_init(17'd65536);
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == 3'(fha_pkg::REG_HEAP_BYTES) * 3'd4)
            heap_init(csr_pwdata[16:0]);
         if (rsp_tvalid && rsp_tready) begin
            got_r.status     = fha_pkg::status_type'(rsp_tuser);
            got_r.payload    = rsp_tdata[15:0];
            got_r.free_total = rsp_tdata[32:16];
            got_r.free_low   = rsp_tdata[49:33];
            got_r.live       = rsp_tdata[62:50];
            got_r.peak       = rsp_tdata[75:63];
            got_r.heap_total = rsp_tdata[92:76];
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat: status %0d data %h", rsp_tuser, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got_r !== exp_r) begin
                  if (fail_count < 10)
                     $display({"result mismatch: expected st %0d pay %h free %0d low %0d ",
                               "live %0d peak %0d heap %0d; got st %0d pay %h free %0d ",
                               "low %0d live %0d peak %0d heap %0d"},
                              exp_r.status, exp_r.payload, exp_r.free_total, exp_r.free_low,
                              exp_r.live, exp_r.peak, exp_r.heap_total,
                              got_r.status, got_r.payload, got_r.free_total, got_r.free_low,
                              got_r.live, got_r.peak, got_r.heap_total);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == fha_pkg::FUNC_ALLOC)
               alloc_block(req_tdata[16:0], st, pay);
            else begin
               free_block(req_tdata[32:17], st);
               pay = 0;
            end
            exp_r.status     = st;
            exp_r.payload    = pay[15:0];
            exp_r.free_total = free_bytes[16:0];
            exp_r.free_low   = free_low[16:0];
            exp_r.live       = live_cnt[12:0];
            exp_r.peak       = peak_cnt[12:0];
            exp_r.heap_total = heap_span[16:0];
            expected_q.push_back(exp_r);
         end
      end
   end

endmodule

`default_nettype wire

// ----- verif/first_fit_heap_allocator_tb.sv -----
// Testbench top for the first-fit heap allocator: drives requests, register writes
// and result back-pressure. Depends on fha_pkg, the block and its checker.
`default_nettype none

module first_fit_heap_allocator_tb;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // req_bytes[16:0], addr[32:17], zero pad
   logic [0:0]  req_tuser = '0;   // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   // payload_addr[15:0], free_total[32:16], free_low_mark[49:33],
   // live_blocks[62:50], live_blocks_peak[75:63], heap_total[92:76], zero pad
   logic [95:0] rsp_tdata;
   logic [2:0]  rsp_tuser;        // status[2:0]
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count, pending;
   int          rx_hold = 0;
   bit          hold_req = 0;
   bit          quiet = 0;
   logic [15:0] live_addrs[$];
   logic [15:0] freed_addrs[$];

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   first_fit_heap_allocator dut (.*);

   first_fit_heap_allocator_checker checker_i (.*);

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         rsp_tready <= 0;
         rx_hold <= 400;
      end else if (rx_hold > 0) begin
         rsp_tready <= 0;
         rx_hold <= rx_hold - 1;
      end else
         rsp_tready <= quiet || $urandom_range(0, 99) >= 12;
   end

   // Successful allocations become candidates for later frees.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tuser == fha_pkg::ST_OK &&
          rsp_tdata[15:0] != 0)
         live_addrs.push_back(rsp_tdata[15:0]);

   task automatic send_beat(logic func, logic [16:0] nbytes, logic [15:0] addr);
      if (!quiet && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= func;
      req_tdata  <= {7'b0, addr, nbytes};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_heap_size(logic [31:0] value);
      drain_results();
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= 3'(fha_pkg::REG_HEAP_BYTES) * 3'd4;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      live_addrs.delete();
      freed_addrs.delete();
   endtask

   task automatic random_beat();
      int unsigned pick, idx;
      logic [15:0] a;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            send_beat(fha_pkg::FUNC_ALLOC, 17'($urandom_range(1, 120)), 16'($urandom));
         else if (pick < 90)
            send_beat(fha_pkg::FUNC_ALLOC, 17'($urandom_range(121, 2000)), 16'($urandom));
         else if (pick < 95)
            send_beat(fha_pkg::FUNC_ALLOC, 17'd0, 16'($urandom));
         else
            send_beat(fha_pkg::FUNC_ALLOC, 17'($urandom), 16'($urandom));
      end else if (pick < 88 && live_addrs.size() > 0) begin
         idx = $urandom_range(0, live_addrs.size() - 1);
         a = live_addrs[idx];
         live_addrs.delete(idx);
         freed_addrs.push_back(a);
         if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
         send_beat(fha_pkg::FUNC_FREE, 17'($urandom), a);
      end else if (pick < 93 && freed_addrs.size() > 0) begin
         // Double free, unless the block was handed out again meanwhile.
         send_beat(fha_pkg::FUNC_FREE, 17'($urandom),
                   freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]);
      end else begin
         a = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
         send_beat(fha_pkg::FUNC_FREE, 17'($urandom), a);
      end
   endtask

   task automatic run_phase(logic [31:0] heap, int beats, bit no_idle, bit squeeze);
      write_heap_size(heap);
      quiet = no_idle;
      for (int i = 0; i < beats; i++) begin
         if (squeeze && i == 40) hold_req = 1;
         if (squeeze && i == 150) drain_results();
         random_beat();
      end
      quiet = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed part on the default full heap.
      send_beat(fha_pkg::FUNC_ALLOC, 17'd0, 16'hFFFF);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd1, 16'd0);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd8, 16'd0);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd9, 16'd0);
      send_beat(fha_pkg::FUNC_ALLOC, 17'h1FFFF, 16'd0);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd65536, 16'd0);
      send_beat(fha_pkg::FUNC_FREE, 17'h1FFFF, 16'd0);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, 16'd4);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, 16'd13);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, 16'hFFFF);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, 16'd65000);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, 16'd8);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, 16'd8);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd100, 16'd0);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd100, 16'd0);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd100, 16'd0);
      drain_results();
      // Free the middle block, then both neighbours, so both merges happen.
      send_beat(fha_pkg::FUNC_FREE, 17'd0, live_addrs[4]);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, live_addrs[3]);
      send_beat(fha_pkg::FUNC_FREE, 17'd0, live_addrs[5]);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd40, 16'd0);
      send_beat(fha_pkg::FUNC_ALLOC, 17'd65528, 16'd0);

      // Heap sizes: over-range, minimum, zero, unaligned, mid, small, full and random.
      run_phase(32'h1FFFF, 40, 0, 0);
      run_phase(32'd16, 40, 0, 0);
      run_phase(32'd0, 30, 0, 0);
      run_phase(32'd17, 30, 0, 0);
      run_phase(32'd2048, 320, 0, 1);
      run_phase(32'd512, 300, 0, 0);
      run_phase(32'd65536, 300, 1, 0);
      run_phase(32'($urandom_range(16, 65536)), 300, 0, 0);

      drain_results();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
